### hdl/ibd_pkg.sv
// Shared types, widths and constants of the interleaved boxcar decimator.
package ibd_pkg;

   localparam int unsigned IBD_MAX_CHANNELS = 3;

   localparam int unsigned SAMPLE_W  = 12;
   localparam int unsigned SLOT_W    = 2;
   localparam int unsigned AVG_W     = 16;
   localparam int unsigned FACTOR_W  = 20;
   localparam int unsigned SUM_W     = 32;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = FACTOR_W;

   // Average scale of 16 is a left shift by 4.
   localparam int unsigned SCALE_SHIFT = 4;
   localparam int unsigned DIVIDEND_W  = SUM_W + SCALE_SHIFT;
   localparam int unsigned DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNELS   = 1'b0,
      CSR_DECIMATION = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [FACTOR_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [AVG_W-1:0] quotient;
   } div_rsp_type;

endpackage

### hdl/ibd_channels.sv
// Handshake channel interfaces of the interleaved boxcar decimator.
interface ibd_req_if
   import ibd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface ibd_rsp_if
   import ibd_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot;
   logic [AVG_W-1:0]  average;
   logic              last;

   modport source (output valid, output slot, output average, output last, input ready);
   modport sink   (input valid, input slot, input average, input last, output ready);
endinterface

interface ibd_csr_if
   import ibd_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/ibd_divider.sv
// Bit-serial restoring divider: one quotient bit per clock.
module ibd_divider
   import ibd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff,  busy_in;
   logic                  done_ff,  done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [FACTOR_W-1:0]   rem_ff,   rem_in;
   logic [DIVIDEND_W-1:0] quo_ff,   quo_in;
   logic [FACTOR_W-1:0]   dsr_ff,   dsr_in;

   logic [FACTOR_W:0]     shifted;
   logic [FACTOR_W+1:0]   diff;

   always_comb begin
      shifted  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff     = {1'b0, shifted} - {2'b00, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (busy_ff) begin
         // keep the remainder when the trial subtraction borrows
         if (!diff[FACTOR_W+1]) begin
            rem_in = diff[FACTOR_W-1:0];
         end else begin
            rem_in = shifted[FACTOR_W-1:0];
         end
         quo_in   = {quo_ff[DIVIDEND_W-2:0], ~diff[FACTOR_W+1]};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = div_req.dividend;
         dsr_in   = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[AVG_W-1:0];

endmodule

### hdl/interleaved_boxcar_decimator.sv
// Top level of the interleaved boxcar decimator. Each accepted req word is a
// 12-bit sample for the next of 1 to 3 round-robin channel slots; it is added
// to that slot's 32-bit running sum. Once every slot has collected
// decimation_factor samples, one rsp word per slot comes out in slot order,
// carrying the low 16 bits of (sum * 16) / decimation_factor, with last set on
// the final slot; the sums then clear. A sample that completes no group is
// accepted, then accumulated. A sample that completes a group is followed,
// per slot, by loading the shared bit-serial divider, its one-bit-per-clock
// quotient steps, capturing the result and presenting the rsp word, which
// then waits for ready. The block takes one req word at a time and stays not
// ready until all rsp words of a group are delivered. Registers (csr index
// 0: channels_in_use, index 1: decimation_factor) are taken only while idle;
// any write restarts the accumulation. A channel count of 0 acts as 1, and a
// factor of 0 acts as 1.
module interleaved_boxcar_decimator
   import ibd_pkg::*;
#(
   parameter int unsigned MAX_CHANNELS = IBD_MAX_CHANNELS
) (
   input  logic      clock,
   input  logic      reset,
   ibd_req_if.sink   req_chan,
   ibd_rsp_if.source rsp_chan,
   ibd_csr_if.sink   csr_chan
);

   // The channel register is 2 bits wide, so no more than 3 slots ever run.
   localparam int unsigned NSLOT      = (MAX_CHANNELS < 3) ? MAX_CHANNELS : 3;
   localparam int unsigned IDX_W      = (NSLOT > 1) ? $clog2(NSLOT) : 1;
   localparam logic [SLOT_W-1:0] NSLOT_CODE = SLOT_W'(NSLOT);

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     chan_ff,  chan_in;
   logic [FACTOR_W-1:0]   fact_ff,  fact_in;
   logic [SLOT_W-1:0]     phase_ff, phase_in;
   logic [FACTOR_W-1:0]   rounds_ff, rounds_in;
   logic [SUM_W-1:0]      sums_ff [NSLOT];
   logic [SUM_W-1:0]      sums_in [NSLOT];
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic [SLOT_W-1:0]     oslot_ff, oslot_in;
   logic [AVG_W-1:0]      avg_ff,   avg_in;

   logic [SLOT_W-1:0]     n_act;
   logic [FACTOR_W-1:0]   d_act;
   logic [SLOT_W-1:0]     phase_cur;
   logic [SLOT_W-1:0]     phase_nxt;
   logic [FACTOR_W:0]     rounds_nxt;
   logic [SLOT_W-1:0]     rd_slot;
   logic [SUM_W-1:0]      rd_sum;
   logic                  req_take;
   logic                  csr_take;
   logic                  rsp_take;
   logic                  group_last;
   logic                  div_start;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   // Clamp the register values into their working ranges.
   always_comb begin
      n_act = chan_ff;
      if (chan_ff == '0) begin
         n_act = SLOT_W'(1);
      end
      if (chan_ff > NSLOT_CODE) begin
         n_act = NSLOT_CODE;
      end
      d_act = (fact_ff == '0) ? FACTOR_W'(1) : fact_ff;
   end

   // One read place serves both the adder and the divider load.
   assign phase_cur  = (phase_ff >= n_act) ? '0 : phase_ff;
   assign phase_nxt  = phase_cur + 1'b1;
   assign rounds_nxt = {1'b0, rounds_ff} + 1'b1;
   assign rd_slot    = (state_ff == ST_ACCUM) ? phase_cur : oslot_ff;
   assign rd_sum     = sums_ff[rd_slot[IDX_W-1:0]];
   assign group_last = (oslot_ff == (n_act - 1'b1));

   assign req_take = req_chan.valid & req_chan.ready;
   assign csr_take = csr_chan.valid & csr_chan.ready;
   assign rsp_take = rsp_chan.valid & rsp_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            // close the group once every slot has its full count
            if (phase_nxt >= n_act && rounds_nxt >= {1'b0, d_act}) begin
               state_in = ST_DIV_START;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               state_in = group_last ? ST_IDLE : ST_DIV_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake and divider control.
   always_comb begin
      csr_chan.ready = 1'b0;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      div_start      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // a register write wins over a sample in the same cycle
            csr_chan.ready = 1'b1;
            req_chan.ready = ~csr_chan.valid;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
         end
         ST_EMIT: begin
            rsp_chan.valid = 1'b1;
         end
         default: begin
            csr_chan.ready = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      chan_in   = chan_ff;
      fact_in   = fact_ff;
      phase_in  = phase_ff;
      rounds_in = rounds_ff;
      sums_in   = sums_ff;
      sample_in = sample_ff;
      oslot_in  = oslot_ff;
      avg_in    = avg_ff;

      if (csr_take) begin
         case (csr_chan.index)
            CSR_CHANNELS: begin
               chan_in = csr_chan.data[SLOT_W-1:0];
            end
            CSR_DECIMATION: begin
               fact_in = csr_chan.data[FACTOR_W-1:0];
            end
            default: begin
               chan_in = chan_ff;
            end
         endcase
         // restart the accumulation on any register write
         phase_in  = '0;
         rounds_in = '0;
         for (int i = 0; i < NSLOT; i++) begin
            sums_in[i] = '0;
         end
      end

      if (req_take) begin
         sample_in = req_chan.sample;
      end

      if (state_ff == ST_ACCUM) begin
         sums_in[rd_slot[IDX_W-1:0]] = rd_sum + SUM_W'(sample_ff);
         if (phase_nxt < n_act) begin
            phase_in = phase_nxt;
         end else begin
            phase_in = '0;
            if (rounds_nxt < {1'b0, d_act}) begin
               rounds_in = rounds_nxt[FACTOR_W-1:0];
            end else begin
               rounds_in = '0;
               oslot_in  = '0;
            end
         end
      end

      if (state_ff == ST_DIV_START) begin
         // the divider holds the sum now, so drop it
         sums_in[rd_slot[IDX_W-1:0]] = '0;
      end

      if (state_ff == ST_DIV_WAIT && div_rsp.done) begin
         avg_in = div_rsp.quotient;
      end

      if (rsp_take) begin
         oslot_in = oslot_ff + 1'b1;
      end
   end

   assign div_req.start    = div_start;
   assign div_req.dividend = {rd_sum, {SCALE_SHIFT{1'b0}}};
   assign div_req.divisor  = d_act;

   ibd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         chan_ff   <= SLOT_W'(1);
         fact_ff   <= FACTOR_W'(1);
         phase_ff  <= '0;
         rounds_ff <= '0;
         oslot_ff  <= '0;
         for (int i = 0; i < NSLOT; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         chan_ff   <= chan_in;
         fact_ff   <= fact_in;
         phase_ff  <= phase_in;
         rounds_ff <= rounds_in;
         oslot_ff  <= oslot_in;
         sums_ff   <= sums_in;
      end
      sample_ff <= sample_in;
      avg_ff    <= avg_in;
   end

   // Hold the rsp word steady until it is taken.
   assign rsp_chan.slot    = oslot_ff;
   assign rsp_chan.average = avg_ff;
   assign rsp_chan.last    = group_last;

endmodule

### sim/tb_interleaved_boxcar_decimator.sv
// Self-checking testbench for the interleaved boxcar decimator.
`timescale 1ns / 100ps

module tb_interleaved_boxcar_decimator
   import ibd_pkg::*;
;

   // One averaged rsp word as the block should deliver it.
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [AVG_W-1:0]  average;
      logic              last;
   } channel_average_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ibd_req_if req_if ();
   ibd_rsp_if rsp_if ();
   ibd_csr_if csr_if ();

   interleaved_boxcar_decimator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #6 clock = ~clock;

   // Samples waiting for the driver, and averages waiting for the monitor.
   logic [SAMPLE_W-1:0] pending_samples[$];
   channel_average_type expected_averages[$];

   // Predictor copy of the block's registers and accumulation state.
   logic [SLOT_W-1:0]   channels_reg;
   logic [FACTOR_W-1:0] factor_reg;
   logic [SUM_W-1:0]    sum_by_slot[IBD_MAX_CHANNELS];
   logic [SLOT_W-1:0]   round_slot;
   logic [FACTOR_W-1:0] rounds_in_group;

   // Percent of cycles in which each side holds off.
   int unsigned sender_idle_pct   = 17;
   int unsigned receiver_idle_pct = 66;

   int unsigned fail_count = 0;

   // Log the first few failures in full; count the rest silently.
   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   // Add one accepted sample to its slot and queue the group's averages once
   // every slot has collected a full set of samples.
   task automatic accumulate_sample(input logic [SAMPLE_W-1:0] sample);
      int unsigned           n_slots;
      logic [FACTOR_W-1:0]   factor;
      logic [DIVIDEND_W-1:0] quotient;
      channel_average_type   word;
      // A channel count of zero acts as one slot; clamp above the maximum.
      n_slots = (channels_reg == '0) ? 1 : int'(channels_reg);
      if (n_slots > IBD_MAX_CHANNELS) n_slots = IBD_MAX_CHANNELS;
      // A decimation factor of zero acts as one.
      factor = (factor_reg == '0) ? FACTOR_W'(1) : factor_reg;
      if (round_slot >= n_slots) round_slot = '0;
      sum_by_slot[round_slot] += SUM_W'(sample);
      round_slot++;
      if (round_slot < n_slots) return;
      round_slot = '0;
      rounds_in_group++;
      if (rounds_in_group < factor) return;
      rounds_in_group = '0;
      for (int c = 0; c < n_slots; c++) begin
         quotient = {sum_by_slot[c], {SCALE_SHIFT{1'b0}}} / DIVIDEND_W'(factor);
         word.slot    = SLOT_W'(c);
         word.average = quotient[AVG_W-1:0];
         word.last    = (c == n_slots - 1);
         expected_averages.push_back(word);
         sum_by_slot[c] = '0;
      end
   endtask

   // Write one register over the csr channel and mirror it in the predictor;
   // any write restarts the accumulation.
   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DAT_W-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_CHANNELS:   channels_reg = value[SLOT_W-1:0];
         CSR_DECIMATION: factor_reg   = value[FACTOR_W-1:0];
         default: ;
      endcase
      foreach (sum_by_slot[i]) sum_by_slot[i] = '0;
      round_slot      = '0;
      rounds_in_group = '0;
   endtask

   // Wait until every sample is taken and every average delivered, then give
   // the block time to finish accumulating a sample that completes no group.
   task automatic settle();
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_if.valid || expected_averages.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Driver: hold a word until it is taken, predict on acceptance, then
   // present the next sample unless this cycle idles.
   always @(posedge clock) begin
      logic fire;
      if (reset) begin
         req_if.valid  <= 1'b0;
         req_if.sample <= '0;
      end else begin
         fire = req_if.valid && req_if.ready;
         if (fire) accumulate_sample(pending_samples.pop_front());
         if (req_if.valid && !fire) begin
            // hold the current word
         end else if (pending_samples.size() != 0 &&
                      $urandom_range(99) >= sender_idle_pct) begin
            req_if.valid  <= 1'b1;
            req_if.sample <= pending_samples[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each delivered word against the oldest expectation, then
   // pick the next cycle's ready.
   always @(posedge clock) begin
      channel_average_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_averages.size() == 0) begin
               note_failure($sformatf("unexpected word slot=%0d average=%0d last=%0b",
                                      rsp_if.slot, rsp_if.average, rsp_if.last));
            end else begin
               want = expected_averages.pop_front();
               if (rsp_if.slot !== want.slot || rsp_if.average !== want.average ||
                   rsp_if.last !== want.last)
                  note_failure($sformatf(
                     "expected slot=%0d average=%0d last=%0b, got slot=%0d average=%0d last=%0b",
                     want.slot, want.average, want.last,
                     rsp_if.slot, rsp_if.average, rsp_if.last));
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Stimulus: directed cases, a long average, the largest factors, then
   // random settings with mostly whole groups.
   initial begin
      int unsigned         random_items;
      int unsigned         n_eff;
      int unsigned         d_eff;
      int unsigned         count;
      logic [CSR_DAT_W-1:0] chan_data;
      logic [CSR_DAT_W-1:0] factor_data;

      csr_if.valid  <= 1'b0;
      csr_if.index  <= CSR_CHANNELS;
      csr_if.data   <= '0;

      // Mirror the reset state of the block.
      channels_reg    = SLOT_W'(1);
      factor_reg      = FACTOR_W'(1);
      foreach (sum_by_slot[i]) sum_by_slot[i] = '0;
      round_slot      = '0;
      rounds_in_group = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: one slot, no averaging; hit the sample extremes.
      pending_samples.push_back(12'h000);
      pending_samples.push_back(12'hFFF);
      pending_samples.push_back(12'h555);
      pending_samples.push_back(12'hAAA);
      pending_samples.push_back(12'h001);
      settle();

      // All three slots, each result from a single sample.
      write_register(CSR_CHANNELS, CSR_DAT_W'(3));
      write_register(CSR_DECIMATION, CSR_DAT_W'(1));
      pending_samples.push_back(12'hFFF);
      pending_samples.push_back(12'h000);
      pending_samples.push_back(12'h7FF);
      settle();

      // Two slots over three rounds; the divide leaves a remainder.
      write_register(CSR_CHANNELS, CSR_DAT_W'(2));
      write_register(CSR_DECIMATION, CSR_DAT_W'(3));
      pending_samples.push_back(12'hFFF);
      pending_samples.push_back(12'hFFF);
      pending_samples.push_back(12'h001);
      pending_samples.push_back(12'h002);
      pending_samples.push_back(12'hFFE);
      pending_samples.push_back(12'h000);
      settle();

      // Zero channels and zero decimation both act as one.
      write_register(CSR_CHANNELS, CSR_DAT_W'(0));
      write_register(CSR_DECIMATION, CSR_DAT_W'(0));
      pending_samples.push_back(12'hFFF);
      pending_samples.push_back(12'h801);
      settle();

      // Leave a group half done, then restart it with a register write.
      write_register(CSR_CHANNELS, CSR_DAT_W'(3));
      write_register(CSR_DECIMATION, CSR_DAT_W'(2));
      pending_samples.push_back(12'hFFF);
      pending_samples.push_back(12'hFFF);
      pending_samples.push_back(12'hFFF);
      settle();
      write_register(CSR_CHANNELS, CSR_DAT_W'(3));
      repeat (6) pending_samples.push_back(random_sample());
      settle();

      // Long average of near-full-scale samples drives the sums high.
      write_register(CSR_DECIMATION, CSR_DAT_W'(100));
      write_register(CSR_CHANNELS, CSR_DAT_W'(1));
      repeat (100) pending_samples.push_back(SAMPLE_W'($urandom_range(3000, 4095)));
      settle();

      // Largest factors: accumulate a little, then drop it with the next write.
      write_register(CSR_CHANNELS, CSR_DAT_W'(3));
      write_register(CSR_DECIMATION, '1);
      repeat (6) pending_samples.push_back(random_sample());
      settle();
      write_register(CSR_DECIMATION, CSR_DAT_W'(1000000));
      repeat (4) pending_samples.push_back(random_sample());
      settle();

      // Random settings. Move the idle mix along by thirds of the items.
      random_items = 0;
      while (random_items < 220) begin
         if (random_items < 73) begin
            sender_idle_pct   = 17;
            receiver_idle_pct = 66;
         end else if (random_items < 147) begin
            sender_idle_pct   = 66;
            receiver_idle_pct = 17;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end

         case ($urandom_range(7))
            0:       chan_data = CSR_DAT_W'($urandom);
            1:       chan_data = '0;
            default: chan_data = CSR_DAT_W'($urandom_range(1, 3));
         endcase
         case ($urandom_range(19))
            0:       factor_data = '0;
            1:       factor_data = '1;
            2:       factor_data = CSR_DAT_W'(1000000);
            3:       factor_data = CSR_DAT_W'($urandom);
            default: factor_data = CSR_DAT_W'($urandom_range(1, 6));
         endcase

         // Write one register, the other, or both in either order.
         case ($urandom_range(3))
            0: begin
               write_register(CSR_CHANNELS, chan_data);
               write_register(CSR_DECIMATION, factor_data);
            end
            1: begin
               write_register(CSR_DECIMATION, factor_data);
               write_register(CSR_CHANNELS, chan_data);
            end
            2:       write_register(CSR_CHANNELS, chan_data);
            default: write_register(CSR_DECIMATION, factor_data);
         endcase

         n_eff = (channels_reg == '0) ? 1 : int'(channels_reg);
         d_eff = (factor_reg == '0) ? 1 : int'(factor_reg);
         if (d_eff > 64) begin
            // Too slow to complete; feed a few samples as noise.
            count = $urandom_range(1, 6);
         end else begin
            // Mostly whole groups; now and then a partial one left behind.
            count = n_eff * d_eff * $urandom_range(1, 4);
            if ($urandom_range(3) == 0) count += $urandom_range(0, n_eff * d_eff - 1);
         end
         repeat (count) pending_samples.push_back(random_sample());
         random_items += count;
         settle();
      end

      // Catch any stray word after the last expected one.
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #(5_000_000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
